>>> hw/rtl/radix2_fft_with_power_spectrum_core_defines.svh
// ----------------------------------------------------------------------------
// radix2_fft_with_power_spectrum_core_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef RADIX2_FFT_WITH_POWER_SPECTRUM_CORE_DEFINES_SVH
`define RADIX2_FFT_WITH_POWER_SPECTRUM_CORE_DEFINES_SVH

// same-cycle implication
`define RFFT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rfft check failed");

// next-cycle implication
`define RFFT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rfft check failed");

`endif

>>> hw/rtl/rfft_pkg.sv
// ----------------------------------------------------------------------------
// rfft_pkg
// types, constants and helper functions of the radix-2 fft core
// ----------------------------------------------------------------------------
package rfft_pkg;

    localparam int POINTS   = 64;
    localparam int ADDR_W   = 6;
    localparam int CNT_W    = 7;
    localparam int LG_W     = 3;
    localparam int SAMPLE_W = 16;
    localparam int DATA_W   = 24;
    localparam int POWER_W  = 48;
    localparam int TW_W     = 17;
    localparam int PROD_W   = DATA_W + TW_W;
    localparam int SUM_W    = PROD_W + 1;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_LENGTH = 2'd1,
        STATUS_OVER   = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] real_part;
        logic signed [DATA_W-1:0] imag_part;
        logic [POWER_W-1:0]       power;
        status_t                  status;
        logic                     final_bin;
    } out_word_t;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [LG_W-1:0]  lg;
        status_t          status;
    } frame_desc_t;

    typedef struct packed {
        logic                       en;
        logic [ADDR_W-1:0]          addr;
        logic signed [SAMPLE_W-1:0] data;
    } samp_wr_t;

    typedef struct packed {
        logic busy;
        logic load_done;
    } back_stat_t;

    typedef struct packed {
        logic signed [TW_W-1:0] c;
        logic signed [TW_W-1:0] s;
    } twiddle_t;

    function automatic logic signed [TW_W-1:0] quarter_cos(input logic [4:0] k);
        logic signed [TW_W-1:0] v;
        case (k)
            5'd0:    v = 17'sd32768;
            5'd1:    v = 17'sd32610;
            5'd2:    v = 17'sd32138;
            5'd3:    v = 17'sd31357;
            5'd4:    v = 17'sd30274;
            5'd5:    v = 17'sd28899;
            5'd6:    v = 17'sd27246;
            5'd7:    v = 17'sd25330;
            5'd8:    v = 17'sd23170;
            5'd9:    v = 17'sd20788;
            5'd10:   v = 17'sd18205;
            5'd11:   v = 17'sd15447;
            5'd12:   v = 17'sd12540;
            5'd13:   v = 17'sd9512;
            5'd14:   v = 17'sd6393;
            5'd15:   v = 17'sd3212;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

    function automatic twiddle_t tw_lookup(input logic [4:0] k);
        twiddle_t t;
        if (k <= 5'd16) begin
            t.c = quarter_cos(k);
            t.s = quarter_cos(5'd16 - k);
        end else begin
            t.c = -quarter_cos(5'd0 - k);
            t.s = quarter_cos(k - 5'd16);
        end
        return t;
    endfunction

    function automatic logic [LG_W-1:0] log2_of(input logic [CNT_W-1:0] n);
        logic [LG_W-1:0] lg;
        lg = '0;
        for (int b = 0; b < CNT_W; b++) begin
            if (n[b]) begin
                lg = LG_W'(b);
            end
        end
        return lg;
    endfunction

    function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] i,
                                                   input logic [LG_W-1:0] lg);
        logic [ADDR_W-1:0] r;
        for (int b = 0; b < ADDR_W; b++) begin
            r[b] = i[ADDR_W-1-b];
        end
        return r >> (LG_W'(ADDR_W) - lg);
    endfunction

endpackage

>>> hw/rtl/rfft_queue.sv
// ----------------------------------------------------------------------------
// rfft_queue
// two-entry frame descriptor queue between front and back
// ----------------------------------------------------------------------------
module rfft_queue
    import rfft_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  frame_desc_t push_data,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output frame_desc_t pop_data
);

    frame_desc_t entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;

    assign full      = fill_reg == 2'd2;
    assign not_empty = fill_reg != 2'd0;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hw/rtl/rfft_front.sv
// ----------------------------------------------------------------------------
// rfft_front
// takes sample words, fills the sample store and classifies each frame
// ----------------------------------------------------------------------------
module rfft_front
    import rfft_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    output samp_wr_t    samp_wr,
    output logic        q_push,
    output frame_desc_t q_data,
    input  logic        q_full,
    input  back_stat_t  back_stat
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             pend_reg, pend_next;
    logic             accept;
    logic             over;
    logic [CNT_W-1:0] n;

    assign s_ready = !pend_reg && !q_full;
    assign accept  = s_valid && s_ready;
    assign over    = count_reg >= CNT_W'(POINTS);
    assign n       = count_reg + CNT_W'(1);

    always_comb begin
        samp_wr.en   = accept && !over;
        samp_wr.addr = count_reg[ADDR_W-1:0];
        samp_wr.data = s_data.sample;

        q_push    = accept && s_data.last;
        q_data.n  = n;
        q_data.lg = log2_of(n);
        if (over) begin
            q_data.status = STATUS_OVER;
        end else if ((n & (n - CNT_W'(1))) != '0) begin
            q_data.status = STATUS_LENGTH;
        end else begin
            q_data.status = STATUS_OK;
        end

        count_next = count_reg;
        if (accept) begin
            if (s_data.last) begin
                count_next = '0;
            end else if (!over) begin
                count_next = n;
            end
        end

        pend_next = pend_reg;
        if (back_stat.load_done) begin
            pend_next = 1'b0;
        end
        if (q_push && q_data.status == STATUS_OK) begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

>>> hw/rtl/rfft_back.sv
// ----------------------------------------------------------------------------
// rfft_back
// loads a frame in bit-reversed order, runs the butterflies on one shared
// unit and streams bins with their power, or zeroed results for error frames
// ----------------------------------------------------------------------------
module rfft_back
    import rfft_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  samp_wr_t    samp_wr,
    input  logic        q_valid,
    input  frame_desc_t q_data,
    output logic        q_pop,
    output back_stat_t  back_stat,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data
);

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b000000000001,
        ST_LD_RD   = 12'b000000000010,
        ST_LD_WR   = 12'b000000000100,
        ST_BF_RD   = 12'b000000001000,
        ST_BF_MUL  = 12'b000000010000,
        ST_BF_ADD  = 12'b000000100000,
        ST_BF_WA   = 12'b000001000000,
        ST_BF_WB   = 12'b000010000000,
        ST_OUT_RD  = 12'b000100000000,
        ST_OUT_SQ  = 12'b001000000000,
        ST_OUT_PUT = 12'b010000000000,
        ST_ERR_PUT = 12'b100000000000
    } state_t;

    localparam int WIDE_W = DATA_W + 4;
    localparam int RND_W  = SUM_W - 15;

    function automatic logic signed [DATA_W-1:0] sat24(input logic signed [WIDE_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > WIDE_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < -WIDE_W'(signed'({1'b0, {(DATA_W-1){1'b1}}})) - WIDE_W'(1)) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    logic signed [SAMPLE_W-1:0] samp_mem [POINTS];
    logic [2*DATA_W-1:0]        work_mem [POINTS];
    logic signed [SAMPLE_W-1:0] samp_q;
    logic [2*DATA_W-1:0]        a_q, b_q;

    state_t           state_reg, state_next;
    frame_desc_t      desc_reg, desc_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [LG_W-1:0]  stage_reg, stage_next;
    logic [4:0]       bf_reg, bf_next;

    logic signed [PROD_W-1:0]  p_rc_reg, p_is_reg, p_ic_reg, p_rs_reg;
    logic signed [DATA_W-1:0]  ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [POWER_W-1:0] sq_re_reg, sq_im_reg;
    logic                      out_valid_reg, out_valid_next;
    out_word_t                 out_reg, out_next;

    logic [ADDR_W-1:0]        bf6, hmask, hbit, ia, ib, kw;
    logic [ADDR_W-1:0]        rd_a, wr_addr;
    logic [2*DATA_W-1:0]      wr_data;
    logic                     wr_en;
    twiddle_t                 tw;
    logic signed [DATA_W-1:0] a_re, a_im, b_re, b_im;
    logic signed [SUM_W-1:0]  sum_r, sum_i;
    logic signed [RND_W-1:0]  tr, ti;
    logic                     out_free;
    logic [CNT_W-1:0]         idx_inc;
    logic [POWER_W-1:0]       pw_sum;

    assign a_re = a_q[2*DATA_W-1:DATA_W];
    assign a_im = a_q[DATA_W-1:0];
    assign b_re = b_q[2*DATA_W-1:DATA_W];
    assign b_im = b_q[DATA_W-1:0];

    // butterfly addressing for the current stage
    always_comb begin
        bf6   = {1'b0, bf_reg};
        hbit  = ADDR_W'(1) << (stage_reg - LG_W'(1));
        hmask = hbit - ADDR_W'(1);
        ia    = ((bf6 >> (stage_reg - LG_W'(1))) << stage_reg) | (bf6 & hmask);
        ib    = ia | hbit;
        kw    = (bf6 & hmask) << (LG_W'(ADDR_W) - stage_reg);
        tw    = tw_lookup(kw[4:0]);
    end

    always_comb begin
        sum_r   = SUM_W'(p_rc_reg) + SUM_W'(p_is_reg) + SUM_W'(16384);
        sum_i   = SUM_W'(p_ic_reg) - SUM_W'(p_rs_reg) + SUM_W'(16384);
        tr      = sum_r[SUM_W-1:15];
        ti      = sum_i[SUM_W-1:15];
        pw_sum  = POWER_W'(sq_re_reg) + POWER_W'(sq_im_reg);
        idx_inc = idx_reg + CNT_W'(1);
        out_free = !out_valid_reg || m_ready;
    end

    always_comb begin
        state_next     = state_reg;
        desc_next      = desc_reg;
        idx_next       = idx_reg;
        stage_next     = stage_reg;
        bf_next        = bf_reg;
        q_pop          = 1'b0;
        back_stat.busy      = state_reg != ST_IDLE;
        back_stat.load_done = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = ia;
        wr_data        = {ar_reg, ai_reg};
        rd_a           = ia;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    desc_next = q_data;
                    idx_next  = '0;
                    if (q_data.status == STATUS_OK) begin
                        state_next = ST_LD_RD;
                    end else begin
                        state_next = ST_ERR_PUT;
                    end
                end
            end
            ST_LD_RD: begin
                state_next = ST_LD_WR;
            end
            ST_LD_WR: begin
                wr_en    = 1'b1;
                wr_addr  = bit_rev(idx_reg[ADDR_W-1:0], desc_reg.lg);
                wr_data  = {DATA_W'(samp_q), {DATA_W{1'b0}}};
                idx_next = idx_inc;
                if (idx_inc == desc_reg.n) begin
                    back_stat.load_done = 1'b1;
                    stage_next = LG_W'(1);
                    bf_next    = '0;
                    if (desc_reg.lg == '0) begin
                        idx_next   = '0;
                        state_next = ST_OUT_RD;
                    end else begin
                        state_next = ST_BF_RD;
                    end
                end else begin
                    state_next = ST_LD_RD;
                end
            end
            ST_BF_RD: begin
                state_next = ST_BF_MUL;
            end
            ST_BF_MUL: begin
                state_next = ST_BF_ADD;
            end
            ST_BF_ADD: begin
                state_next = ST_BF_WA;
            end
            ST_BF_WA: begin
                wr_en      = 1'b1;
                wr_addr    = ia;
                wr_data    = {ar_reg, ai_reg};
                state_next = ST_BF_WB;
            end
            ST_BF_WB: begin
                wr_en      = 1'b1;
                wr_addr    = ib;
                wr_data    = {br_reg, bi_reg};
                state_next = ST_BF_RD;
                if ({1'b0, bf_reg} + 6'd1 == desc_reg.n[CNT_W-1:1]) begin
                    bf_next = '0;
                    if (stage_reg == desc_reg.lg) begin
                        idx_next   = '0;
                        state_next = ST_OUT_RD;
                    end else begin
                        stage_next = stage_reg + LG_W'(1);
                    end
                end else begin
                    bf_next = bf_reg + 5'd1;
                end
            end
            ST_OUT_RD: begin
                rd_a       = idx_reg[ADDR_W-1:0];
                state_next = ST_OUT_SQ;
            end
            ST_OUT_SQ: begin
                rd_a       = idx_reg[ADDR_W-1:0];
                state_next = ST_OUT_PUT;
            end
            ST_OUT_PUT: begin
                rd_a = idx_reg[ADDR_W-1:0];
                if (out_free) begin
                    out_valid_next     = 1'b1;
                    out_next.real_part = a_re;
                    out_next.imag_part = a_im;
                    out_next.power     = pw_sum >> desc_reg.lg;
                    out_next.status    = STATUS_OK;
                    out_next.final_bin = idx_inc == desc_reg.n;
                    idx_next           = idx_inc;
                    state_next         = (idx_inc == desc_reg.n) ? ST_IDLE : ST_OUT_RD;
                end
            end
            ST_ERR_PUT: begin
                if (out_free) begin
                    out_valid_next     = 1'b1;
                    out_next.real_part = '0;
                    out_next.imag_part = '0;
                    out_next.power     = '0;
                    out_next.status    = desc_reg.status;
                    out_next.final_bin = (desc_reg.status == STATUS_OVER)
                                      || (idx_inc == desc_reg.n);
                    idx_next           = idx_inc;
                    if (out_next.final_bin) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        desc_reg  <= desc_next;
        idx_reg   <= idx_next;
        stage_reg <= stage_next;
        bf_reg    <= bf_next;
        out_reg   <= out_next;
        p_rc_reg  <= b_re * tw.c;
        p_is_reg  <= b_im * tw.s;
        p_ic_reg  <= b_im * tw.c;
        p_rs_reg  <= b_re * tw.s;
        sq_re_reg <= a_re * a_re;
        sq_im_reg <= a_im * a_im;
        if (state_reg == ST_BF_ADD) begin
            ar_reg <= sat24(WIDE_W'(a_re) + WIDE_W'(tr));
            ai_reg <= sat24(WIDE_W'(a_im) + WIDE_W'(ti));
            br_reg <= sat24(WIDE_W'(a_re) - WIDE_W'(tr));
            bi_reg <= sat24(WIDE_W'(a_im) - WIDE_W'(ti));
        end
    end

    // sample store
    always_ff @(posedge aclk) begin
        if (samp_wr.en) begin
            samp_mem[samp_wr.addr] <= samp_wr.data;
        end
        samp_q <= samp_mem[idx_reg[ADDR_W-1:0]];
    end

    // work store
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            work_mem[wr_addr] <= wr_data;
        end
        a_q <= work_mem[rd_a];
        b_q <= work_mem[ib];
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> hw/rtl/radix2_fft_with_power_spectrum_core.sv
// ----------------------------------------------------------------------------
// radix2_fft_with_power_spectrum_core
// radix-2 dit fft of real frames up to 64 points with periodogram power
// ----------------------------------------------------------------------------
// channel   dir   handshake            word
// s_        in    s_valid / s_ready    sample, last
// m_        out   m_valid / m_ready    real_part, imag_part, power, status, final_bin
//
// samples: one per cycle while the queue has room and every valid frame has been loaded
// valid frame of n: a pop, a load of its n samples, n/2 * log2 n butterflies on the
//   shared butterfly unit, then the bins
// error frames: one result per cycle while m_ready does not stall the output
// reset: synchronous, active low aresetn; no clearing pass
// a stalled m_ready holds the back end; the front keeps taking samples until the
//   queue is full or a valid frame is not yet fully loaded
module radix2_fft_with_power_spectrum_core
    import rfft_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    samp_wr_t    samp_wr;
    logic        q_push, q_full, q_pop, q_valid;
    frame_desc_t q_push_data, q_pop_data;
    back_stat_t  back_stat;

    rfft_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .samp_wr   (samp_wr),
        .q_push    (q_push),
        .q_data    (q_push_data),
        .q_full    (q_full),
        .back_stat (back_stat)
    );

    rfft_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_pop_data)
    );

    rfft_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .samp_wr   (samp_wr),
        .q_valid   (q_valid),
        .q_data    (q_pop_data),
        .q_pop     (q_pop),
        .back_stat (back_stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> hw/rtl/rfft_checker.sv
// ----------------------------------------------------------------------------
// rfft_checker
// port-level checks bound to the fft core
// ----------------------------------------------------------------------------
`include "radix2_fft_with_power_spectrum_core_defines.svh"

module rfft_checker
    import rfft_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    `RFFT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    `RFFT_ASSERT_NOW(a_over_final, aclk, aresetn, m_valid && m_data.status == STATUS_OVER, m_data.final_bin)

    `RFFT_ASSERT_NOW(a_err_zero, aclk, aresetn, m_valid && m_data.status != STATUS_OK, m_data.power == '0 && m_data.real_part == '0 && m_data.imag_part == '0)

endmodule

bind radix2_fft_with_power_spectrum_core rfft_checker u_checker (.*);
